// ===== hw/rtl/mlptb_pkg.sv =====
// shared types, constants and fixed-point helpers for the mlp trainer
package mlptb_pkg;

    localparam int FRAC_BITS = 12;
    localparam int VW        = 20;
    localparam logic signed [VW-1:0] ONE_V = VW'(1 << FRAC_BITS);

    localparam logic [1:0] MODE_TRAIN = 2'd0;
    localparam logic [1:0] MODE_INFER = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    typedef enum logic [3:0] {
        LOP_NONE, LOP_H0, LOP_H1, LOP_HP, LOP_OT,
        LOP_U0, LOP_U1, LOP_U2, LOP_U3, LOP_U4, LOP_U5, LOP_U6, LOP_U7
    } lane_op_t;

    typedef enum logic [3:0] {
        MOP_NONE, MOP_CLR, MOP_ADD, MOP_PLAN, MOP_SQ, MOP_D, MOP_OG, MOP_LG, MOP_OB
    } merge_op_t;

    typedef struct packed {
        logic              en;
        logic [3:0]        idx;
        logic signed [15:0] val;
    } wr_t;

    // round to nearest, ties up
    function automatic logic signed [VW-1:0] mulq(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b);
        logic signed [2*VW-1:0] p;
        p = a * b + (2*VW)'(1 << (FRAC_BITS - 1));
        return p[FRAC_BITS+VW-1:FRAC_BITS];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [VW:0] v);
        if (v > (VW+1)'(32767))
            return 16'sh7fff;
        else if (v < -(VW+1)'(32768))
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    // piecewise-linear sigmoid
    function automatic logic [12:0] plan(input logic signed [15:0] x);
        logic [16:0] a;
        logic [16:0] y;
        a = x[15] ? 17'(-18'(x)) : 17'(x);
        if (a >= 17'd20480)
            y = 17'd4096;
        else if (a >= 17'd9728)
            y = (a >> 5) + 17'd3456;
        else if (a >= 17'd4096)
            y = (a >> 3) + 17'd2560;
        else
            y = (a >> 2) + 17'd2048;
        if (x[15])
            y = 17'd4096 - y;
        return y[12:0];
    endfunction

endpackage

// ===== hw/rtl/mlptb_lane.sv =====
// one hidden neuron: its weights, forward term and backprop update
module mlptb_lane
    import mlptb_pkg::*;
#(
    parameter int LANE = 0,
    parameter int NUM_HIDDEN = 2
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lane_op_t             op,
    input  wr_t                  wr,
    input  logic signed [15:0]   fa,
    input  logic signed [15:0]   fb,
    input  logic [12:0]          lr,
    input  logic signed [VW-1:0] og,
    input  logic signed [VW-1:0] lg,
    output logic signed [VW-1:0] term
);
    localparam logic [7:0] IDX_A = 8'(3 * LANE);
    localparam logic [7:0] IDX_B = 8'(3 * LANE + 1);
    localparam logic [7:0] IDX_C = 8'(3 * LANE + 2);
    localparam logic [7:0] IDX_O = 8'(3 * NUM_HIDDEN + LANE);

    logic signed [15:0]   wa_reg, wb_reg, wc_reg, wo_reg, acc_reg;
    logic [12:0]          h_reg;
    logic signed [VW-1:0] dh_reg, tmp_reg;
    logic signed [VW-1:0] ma, mb, prod, h_v;
    logic [7:0]           widx;

    assign h_v  = VW'(signed'({1'b0, h_reg}));
    assign widx = 8'(wr.idx);
    assign term = tmp_reg;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (op)
            LOP_H0:  begin ma = VW'(fa);  mb = VW'(wa_reg); end
            LOP_H1:  begin ma = VW'(fb);  mb = VW'(wb_reg); end
            LOP_OT:  begin ma = h_v;      mb = VW'(wo_reg); end
            LOP_U0:  begin ma = lg;       mb = h_v; end
            LOP_U1:  begin ma = h_v;      mb = ONE_V - h_v; end
            LOP_U2:  begin ma = og;       mb = VW'(wo_reg); end
            LOP_U3:  begin ma = tmp_reg;  mb = dh_reg; end
            LOP_U4:  begin ma = VW'(signed'({1'b0, lr})); mb = tmp_reg; end
            LOP_U5:  begin ma = tmp_reg;  mb = VW'(fa); end
            LOP_U6:  begin ma = tmp_reg;  mb = VW'(fb); end
            default: begin ma = '0;       mb = '0; end
        endcase
    end

    assign prod = mulq(ma, mb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wa_reg <= '0;
            wb_reg <= '0;
            wc_reg <= '0;
            wo_reg <= '0;
        end
        else if (wr.en)
        begin
            if (widx == IDX_A) wa_reg <= wr.val;
            if (widx == IDX_B) wb_reg <= wr.val;
            if (widx == IDX_C) wc_reg <= wr.val;
            if (widx == IDX_O) wo_reg <= wr.val;
        end
        else
        begin
            case (op)
                LOP_U0:  wo_reg <= sat16((VW+1)'(wo_reg) + (VW+1)'(prod));
                LOP_U5:  wa_reg <= sat16((VW+1)'(wa_reg) + (VW+1)'(prod));
                LOP_U6:  wb_reg <= sat16((VW+1)'(wb_reg) + (VW+1)'(prod));
                LOP_U7:  wc_reg <= sat16((VW+1)'(wc_reg) + (VW+1)'(tmp_reg));
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            LOP_H0:  acc_reg <= sat16((VW+1)'(wc_reg) + (VW+1)'(prod));
            LOP_H1:  acc_reg <= sat16((VW+1)'(acc_reg) + (VW+1)'(prod));
            LOP_HP:  h_reg   <= plan(acc_reg);
            LOP_U1:  dh_reg  <= prod;
            LOP_OT, LOP_U2, LOP_U3, LOP_U4: tmp_reg <= prod;
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/mlptb_merge.sv =====
// output neuron: sums lane terms, output sigmoid, error and output gradient
module mlptb_merge
    import mlptb_pkg::*;
#(
    parameter int NUM_HIDDEN = 2,
    parameter int CW = 1
)(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  merge_op_t                            op,
    input  logic [CW-1:0]                        sel,
    input  logic signed [NUM_HIDDEN-1:0][VW-1:0] terms,
    input  wr_t                                  wr,
    input  logic [12:0]                          tgt,
    input  logic [12:0]                          lr,
    output logic [12:0]                          y,
    output logic signed [13:0]                   err,
    output logic [12:0]                          sq,
    output logic signed [VW-1:0]                 og,
    output logic signed [VW-1:0]                 lg
);
    localparam logic [7:0] IDX_OB = 8'(4 * NUM_HIDDEN);

    logic signed [15:0]   s_reg, ob_reg;
    logic [12:0]          y_reg, sq_reg;
    logic signed [13:0]   err_reg, err_v;
    logic signed [VW-1:0] d_reg, og_reg, lg_reg, y_v, ma, mb, prod;

    assign y_v   = VW'(signed'({1'b0, y_reg}));
    assign err_v = signed'({1'b0, tgt}) - signed'({1'b0, y_reg});

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (op)
            MOP_SQ:  begin ma = VW'(err_v);   mb = VW'(err_v); end
            MOP_D:   begin ma = y_v;          mb = ONE_V - y_v; end
            MOP_OG:  begin ma = VW'(err_reg); mb = d_reg; end
            MOP_LG:  begin ma = VW'(signed'({1'b0, lr})); mb = og_reg; end
            default: begin ma = '0;           mb = '0; end
        endcase
    end

    assign prod = mulq(ma, mb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ob_reg <= '0;
        else if (wr.en)
        begin
            if (8'(wr.idx) == IDX_OB) ob_reg <= wr.val;
        end
        else if (op == MOP_OB)
            ob_reg <= sat16((VW+1)'(ob_reg) + (VW+1)'(lg_reg));
    end

    always_ff @(posedge clk)
    begin
        case (op)
            MOP_CLR:  s_reg <= ob_reg;
            MOP_ADD:  s_reg <= sat16((VW+1)'(s_reg) + (VW+1)'(signed'(terms[sel])));
            MOP_PLAN: y_reg <= plan(s_reg);
            MOP_SQ:
            begin
                err_reg <= err_v;
                sq_reg  <= prod[12:0];
            end
            MOP_D:    d_reg  <= prod;
            MOP_OG:   og_reg <= prod;
            MOP_LG:   lg_reg <= prod;
            default: ;
        endcase
    end

    assign y   = y_reg;
    assign err = err_reg;
    assign sq  = sq_reg;
    assign og  = og_reg;
    assign lg  = lg_reg;

endmodule

// ===== hw/rtl/mlp_train_step_backprop.sv =====
// top level: sequencer, hidden lanes, output merge and stream ports
// One word in, one word out. All hidden neurons run side by side in their own lanes, each with
// one multiplier; the output neuron sums the lane terms one lane per cycle. A train word runs the
// forward, error and update states, an infer word the forward ones, a write or the unused mode none;
// the next word is taken once the previous one has finished, since it needs the updated weights.
// The result sits in an output register, so a stalled output delays only the next finish.
module mlp_train_step_backprop
    import mlptb_pkg::*;
#(
    parameter int NUM_HIDDEN = 2
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,    // learn_rate
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // feature_a, feature_b, target_value, weight_index, weight_value
    input  logic [1:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // prediction, error_value, squared_error
);
    localparam int CW = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;

    typedef enum logic [19:0] {
        S_IDLE = 20'h00001, S_H0 = 20'h00002, S_H1 = 20'h00004, S_HP = 20'h00008,
        S_OT = 20'h00010, S_CLR = 20'h00020, S_ADD = 20'h00040, S_PLAN = 20'h00080,
        S_SQ = 20'h00100, S_D = 20'h00200, S_OG = 20'h00400, S_LG = 20'h00800,
        S_U0 = 20'h01000, S_U1 = 20'h02000, S_U2 = 20'h04000, S_U3 = 20'h08000,
        S_U4 = 20'h10000, S_U5 = 20'h20000, S_U6 = 20'h40000, S_FIN = 20'h80000
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [12:0]          lr_reg;
    logic [1:0]           mode_reg;
    logic signed [15:0]   fa_reg, fb_reg;
    logic [12:0]          tgt_reg;
    logic                 out_valid_reg;
    logic [12:0]          out_pred_reg, out_sq_reg;
    logic signed [13:0]   out_err_reg;
    logic                 accept, load_out, u7;
    logic [1:0]           in_mode;
    logic [12:0]          in_tgt;
    wr_t                  wr;
    lane_op_t             lop;
    merge_op_t            mop;
    logic signed [NUM_HIDDEN-1:0][VW-1:0] terms;
    logic [12:0]          y;
    logic signed [13:0]   err;
    logic [12:0]          sq;
    logic signed [VW-1:0] og, lg;

    assign in_mode       = s_axis_tuser;
    assign in_tgt        = s_axis_tdata[44:32];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load_out      = (state_reg == S_FIN) && (!out_valid_reg || m_axis_tready);

    assign wr.en  = accept && (in_mode == MODE_WRITE);
    assign wr.idx = s_axis_tdata[48:45];
    assign wr.val = s_axis_tdata[64:49];

    // hidden bias update rides along with the last state after the input weights
    assign u7 = (state_reg == S_FIN) && (mode_reg == MODE_TRAIN);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lop        = LOP_NONE;
        mop        = MOP_NONE;
        case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = (in_mode == MODE_TRAIN || in_mode == MODE_INFER) ? S_H0 : S_FIN;
            S_H0:   begin lop = LOP_H0; state_next = S_H1; end
            S_H1:   begin lop = LOP_H1; state_next = S_HP; end
            S_HP:   begin lop = LOP_HP; state_next = S_OT; end
            S_OT:   begin lop = LOP_OT; state_next = S_CLR; end
            S_CLR:  begin mop = MOP_CLR; cnt_next = '0; state_next = S_ADD; end
            S_ADD:
            begin
                mop = MOP_ADD;
                if (cnt_reg == CW'(NUM_HIDDEN - 1))
                    state_next = S_PLAN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_PLAN:
            begin
                mop = MOP_PLAN;
                state_next = (mode_reg == MODE_TRAIN) ? S_SQ : S_FIN;
            end
            S_SQ:   begin mop = MOP_SQ; state_next = S_D; end
            S_D:    begin mop = MOP_D;  state_next = S_OG; end
            S_OG:   begin mop = MOP_OG; state_next = S_LG; end
            S_LG:   begin mop = MOP_LG; state_next = S_U0; end
            S_U0:   begin lop = LOP_U0; mop = MOP_OB; state_next = S_U1; end
            S_U1:   begin lop = LOP_U1; state_next = S_U2; end
            S_U2:   begin lop = LOP_U2; state_next = S_U3; end
            S_U3:   begin lop = LOP_U3; state_next = S_U4; end
            S_U4:   begin lop = LOP_U4; state_next = S_U5; end
            S_U5:   begin lop = LOP_U5; state_next = S_U6; end
            S_U6:   begin lop = LOP_U6; state_next = S_FIN; end
            S_FIN:
            begin
                // bias update must happen exactly once, so only when leaving
                if (u7 && load_out)
                    lop = LOP_U7;
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            lr_reg        <= 13'd410;
            mode_reg      <= MODE_TRAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en)
                lr_reg <= cfg_wr_data;
            if (accept)
                mode_reg <= in_mode;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fa_reg  <= s_axis_tdata[15:0];
            fb_reg  <= s_axis_tdata[31:16];
            tgt_reg <= (in_tgt > 13'd4096) ? 13'd4096 : in_tgt;
        end
        if (load_out)
        begin
            out_pred_reg <= (mode_reg == MODE_TRAIN || mode_reg == MODE_INFER) ? y : '0;
            out_err_reg  <= (mode_reg == MODE_TRAIN) ? err : '0;
            out_sq_reg   <= (mode_reg == MODE_TRAIN) ? sq : '0;
        end
    end

    for (genvar i = 0; i < NUM_HIDDEN; i++)
    begin : g_lane
        mlptb_lane #(
            .LANE       (i),
            .NUM_HIDDEN (NUM_HIDDEN)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .op    (lop),
            .wr    (wr),
            .fa    (fa_reg),
            .fb    (fb_reg),
            .lr    (lr_reg),
            .og    (og),
            .lg    (lg),
            .term  (terms[i])
        );
    end

    mlptb_merge #(
        .NUM_HIDDEN (NUM_HIDDEN),
        .CW         (CW)
    ) u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mop),
        .sel   (cnt_reg),
        .terms (terms),
        .wr    (wr),
        .tgt   (tgt_reg),
        .lr    (lr_reg),
        .y     (y),
        .err   (err),
        .sq    (sq),
        .og    (og),
        .lg    (lg)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_sq_reg, out_err_reg, out_pred_reg};

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_pred_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_pred_reg <= 13'd4096))
        else $error("prediction above one");

    a_no_err_untrained: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && mode_reg != MODE_TRAIN) |=> (out_err_reg == '0 && out_sq_reg == '0))
        else $error("error reported outside train mode");

    a_finish_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (state_reg == S_IDLE && m_axis_tvalid))
        else $error("finished word not presented");
`endif

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the mlp trainer: random stream traffic against a built-in predictor
`timescale 1ns / 100ps

module tb_top;
    import mlptb_pkg::*;

    localparam int HIDDEN = 2;
    localparam int DEPTH  = 4 * HIDDEN + 1;
    localparam longint UNIT = 64'sd4096;

    typedef struct {
        logic [12:0] prediction;
        logic [13:0] error_value;
        logic [12:0] squared_error;
    } net_result_t;

    class net_scoreboard;
        longint      weights[DEPTH];
        longint      rate;
        net_result_t expected_q[$];
        int          mismatches;
        int          results_seen;
        int          trains;
        int          infers;
        int          writes;

        function new();
            foreach (weights[i])
                weights[i] = 0;
            rate = 410;
            mismatches = 0;
            results_seen = 0;
            trains = 0;
            infers = 0;
            writes = 0;
        endfunction

        function longint clip16(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        // exact product, add half, floor divide
        function longint qmul(longint a, longint b);
            longint p;
            p = a * b + (UNIT >>> 1);
            return p >>> 12;
        endfunction

        function longint sigmoid(longint x);
            longint a;
            longint y;
            a = (x < 0) ? -x : x;
            if (a >= 5 * UNIT)
                y = UNIT;
            else if (a >= 19 * (UNIT >>> 3))
                y = (a >>> 5) + 27 * (UNIT >>> 5);
            else if (a >= UNIT)
                y = (a >>> 3) + 5 * (UNIT >>> 3);
            else
                y = (a >>> 2) + (UNIT >>> 1);
            return (x < 0) ? UNIT - y : y;
        endfunction

        function void note_input(logic [1:0] mode, logic [71:0] word);
            longint fa;
            longint fb;
            longint tgt;
            longint wval;
            int     widx;
            longint h[HIDDEN];
            longint s;
            longint y;
            longint err;
            longint sq;
            longint og;
            longint lg;
            longint hg;
            longint lh;
            net_result_t r;
            fa   = longint'($signed(word[15:0]));
            fb   = longint'($signed(word[31:16]));
            tgt  = longint'(word[44:32]);
            widx = int'(word[48:45]);
            wval = longint'($signed(word[64:49]));
            r.prediction = '0;
            r.error_value = '0;
            r.squared_error = '0;
            err = 0;
            sq = 0;
            if (mode == MODE_WRITE) begin
                writes++;
                if (widx < DEPTH)
                    weights[widx] = wval;
            end else if (mode == MODE_TRAIN || mode == MODE_INFER) begin
                for (int i = 0; i < HIDDEN; i++) begin
                    s = weights[3*i+2];
                    s = clip16(s + qmul(fa, weights[3*i]));
                    s = clip16(s + qmul(fb, weights[3*i+1]));
                    h[i] = sigmoid(s);
                end
                s = weights[4*HIDDEN];
                for (int i = 0; i < HIDDEN; i++)
                    s = clip16(s + qmul(h[i], weights[3*HIDDEN+i]));
                y = sigmoid(s);
                if (mode == MODE_TRAIN) begin
                    trains++;
                    if (tgt > UNIT)
                        tgt = UNIT;
                    err = tgt - y;
                    sq = qmul(err, err);
                    og = qmul(err, qmul(y, UNIT - y));
                    lg = qmul(rate, og);
                    for (int i = 0; i < HIDDEN; i++)
                        weights[3*HIDDEN+i] = clip16(weights[3*HIDDEN+i] + qmul(lg, h[i]));
                    weights[4*HIDDEN] = clip16(weights[4*HIDDEN] + lg);
                    // hidden gradient sees the freshly updated output weights
                    for (int i = 0; i < HIDDEN; i++) begin
                        hg = qmul(qmul(og, weights[3*HIDDEN+i]), qmul(h[i], UNIT - h[i]));
                        lh = qmul(rate, hg);
                        weights[3*i]   = clip16(weights[3*i] + qmul(lh, fa));
                        weights[3*i+1] = clip16(weights[3*i+1] + qmul(lh, fb));
                        weights[3*i+2] = clip16(weights[3*i+2] + lh);
                    end
                end else begin
                    infers++;
                end
                r.prediction = 13'(y);
                r.error_value = 14'(err);
                r.squared_error = 13'(sq);
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [39:0] word);
            net_result_t e;
            logic [12:0] pred;
            logic [13:0] err;
            logic [12:0] sq;
            pred = word[12:0];
            err = word[26:13];
            sq = word[39:27];
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", word);
                return;
            end
            e = expected_q.pop_front();
            if (pred !== e.prediction || err !== e.error_value || sq !== e.squared_error) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected pred %h err %h sq %h, got pred %h err %h sq %h",
                             results_seen, e.prediction, e.error_value, e.squared_error,
                             pred, err, sq);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [12:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // feature_a, feature_b, target_value, weight_index, weight_value
    logic [1:0]  s_axis_tuser;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // prediction, error_value, squared_error

    net_scoreboard sb;
    int burst_left;
    int stall_style;
    int cycle_count;
    int rates_used;

    mlp_train_step_backprop #(.NUM_HIDDEN(HIDDEN)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("timeout waiting for results");
        $display("[mlp_train_step_backprop] ERROR");
        $finish;
    end

    // receiver stall pattern switches at random among four styles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            cycle_count <= 0;
            stall_style <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            if (cycle_count % 300 == 299)
                stall_style <= $urandom_range(0, 3);
            case (stall_style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ($urandom_range(0, 19) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(s_axis_tuser, s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    task automatic put_word(input logic [1:0] mode, input logic signed [15:0] fa,
                            input logic signed [15:0] fb, input logic [12:0] tgt,
                            input logic [3:0] widx, input logic signed [15:0] wval);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= {7'd0, wval, widx, tgt, fb, fa};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 15);
        end
    endtask

    task automatic set_rate(input logic [12:0] value);
        s_axis_tvalid <= 1'b0;
        burst_left = $urandom_range(1, 15);
        // let the last accepted word reach the scoreboard first
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.rate = longint'(value);
        rates_used++;
    endtask

    function automatic logic signed [15:0] pick_feature();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(0, 12288)) - 6144);
    endfunction

    task automatic load_weights(input int span);
        for (int i = 0; i < DEPTH; i++)
            put_word(MODE_WRITE, 16'($urandom), 16'($urandom), 13'($urandom), 4'(i),
                     16'($signed($urandom_range(0, 2*span)) - span));
    endtask

    task automatic random_phase(input int count);
        int k;
        logic [12:0] tgt;
        k = 0;
        while (k < count) begin
            if (k % 60 == 0) begin
                load_weights($urandom_range(0, 3) == 0 ? 32767 : 8192);
                k += DEPTH;
            end
            case ($urandom_range(0, 19))
                0: put_word(MODE_WRITE, 16'($urandom), 16'($urandom), 13'($urandom),
                            4'($urandom), 16'($urandom));
                1: put_word(2'd3, 16'($urandom), 16'($urandom), 13'($urandom),
                            4'($urandom), 16'($urandom));
                2, 3, 4: put_word(MODE_INFER, pick_feature(), pick_feature(),
                                  13'($urandom), 4'($urandom), 16'($urandom));
                default: begin
                    tgt = ($urandom_range(0, 4) == 0) ? 13'($urandom)
                                                      : ($urandom_range(0, 1) ? 13'd4096 : 13'd0);
                    put_word(MODE_TRAIN, pick_feature(), pick_feature(), tgt,
                             4'($urandom), 16'($urandom));
                end
            endcase
            k++;
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_TRAIN;
        burst_left = 4;
        rates_used = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero weights, field extremes, every mode, ignored writes
        put_word(MODE_INFER, 16'sh7fff, 16'sh8000, 13'd0, 4'd0, 16'sd0);
        put_word(MODE_TRAIN, 16'sh4000, 16'shc000, 13'd4096, 4'd0, 16'sd0);
        put_word(MODE_TRAIN, 16'sh1000, 16'sh1000, 13'h1fff, 4'd0, 16'sd0);
        put_word(MODE_TRAIN, 16'sh0000, 16'sh1000, 13'd0, 4'd0, 16'sd0);
        put_word(MODE_WRITE, 16'sh7fff, 16'sh7fff, 13'h1fff, 4'd9, 16'sh7fff);
        put_word(MODE_WRITE, 16'sh0, 16'sh0, 13'd0, 4'd15, 16'sh8000);
        put_word(2'd3, 16'sh7fff, 16'sh8000, 13'h1fff, 4'd15, 16'sh7fff);
        put_word(MODE_WRITE, 16'sh0, 16'sh0, 13'd0, 4'd0, 16'sh7fff);
        put_word(MODE_WRITE, 16'sh0, 16'sh0, 13'd0, 4'd1, 16'sh8000);
        put_word(MODE_WRITE, 16'sh0, 16'sh0, 13'd0, 4'd2, 16'sh2000);
        put_word(MODE_WRITE, 16'sh0, 16'sh0, 13'd0, 4'd6, 16'sh7fff);
        put_word(MODE_WRITE, 16'sh0, 16'sh0, 13'd0, 4'd7, 16'shc000);
        put_word(MODE_WRITE, 16'sh0, 16'sh0, 13'd0, 4'd8, 16'sh8000);
        put_word(MODE_INFER, 16'sh7fff, 16'sh7fff, 13'd0, 4'd0, 16'sd0);
        put_word(MODE_TRAIN, 16'sh7fff, 16'sh8000, 13'd4096, 4'd0, 16'sd0);
        put_word(MODE_TRAIN, 16'sh8000, 16'sh7fff, 13'd0, 4'd0, 16'sd0);
        put_word(MODE_TRAIN, 16'sh0800, 16'shf800, 13'd2048, 4'd0, 16'sd0);
        put_word(MODE_INFER, 16'sh0, 16'sh0, 13'd0, 4'd0, 16'sd0);

        random_phase(180);
        set_rate(13'd0);
        random_phase(100);
        set_rate(13'd4096);
        random_phase(140);
        set_rate(13'h1fff);
        random_phase(100);
        set_rate(13'($urandom_range(1, 4095)));
        random_phase(160);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("covered %0d train, %0d infer and %0d write words over %0d learning rates",
                 sb.trains, sb.infers, sb.writes, rates_used + 1);
        $display("%0d results checked, %0d mismatches", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("[mlp_train_step_backprop] OK");
        else
            $display("[mlp_train_step_backprop] ERROR");
        $finish;
    end

endmodule
